// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define CHK_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define CHK_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define CHK_PROP(label, clk, rst, prop)
`define CHK_NEVER(label, clk, rst, expr)
`endif

`endif

// File: design/lpf4_pkg.sv
// ----------------------------------------------------------------------------
// lpf4_pkg
// types and constants of the multichannel fourth-order lowpass
// ----------------------------------------------------------------------------
package lpf4_pkg;

   localparam int MAX_CHANNELS_DEF = 16;
   localparam int SAMPLE_W = 24;
   localparam int CHAN_W   = 4;
   localparam int GAIN_W   = 48;
   localparam int COEF_W   = 52;
   localparam int CSR_IDX_W = 3;
   localparam int ROW_W    = 4 * SAMPLE_W;
   localparam int NUM_W    = 28;
   localparam int PROD_W   = COEF_W + NUM_W;
   localparam int ACC_W    = 86;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FB1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FB2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FB3  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FB4  = 3'd4;

   // item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   // product selects
   localparam logic [2:0] SEL_GAIN = 3'd0;
   localparam logic [2:0] SEL_LAST = 3'd4;

   typedef struct packed {
      logic                       kind;
      logic [CHAN_W-1:0]          chan;
      logic signed [SAMPLE_W-1:0] in_sample;
   } lpf4_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]          out_chan;
      logic signed [SAMPLE_W-1:0] out_sample;
      logic                       saturated;
   } lpf4_rsp_type;

   typedef struct packed {
      logic       take;
      logic       clear_all;
      logic       load_num;
      logic       mul_en;
      logic [2:0] mul_sel;
      logic       finish;
   } lpf4_cmd_type;

   typedef struct packed {
      logic req_clear;
      logic req_in_range;
      logic out_busy;
   } lpf4_sts_type;

endpackage

// File: design/lpf4_dp.sv
// ----------------------------------------------------------------------------
// lpf4_dp
// history memories, coefficient registers, shared multipliers, accumulator
// and result register
// ----------------------------------------------------------------------------
module lpf4_dp import lpf4_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lpf4_req_type         req_payload,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lpf4_rsp_type         rsp_payload,
   input  lpf4_cmd_type         cmd,
   output lpf4_sts_type         sts
);

   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   logic [GAIN_W-1:0]        gain_ff;
   logic signed [COEF_W-1:0] fb_ff [4];

   logic [ROW_W-1:0]    mem_x [MAX_CHANNELS];
   logic [ROW_W-1:0]    mem_y [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] row_valid_ff;

   logic [ROW_W-1:0]    rd_x_ff, rd_y_ff;
   logic                rd_valid_ff;
   logic [CH_W-1:0]     idx_ff;
   logic [CHAN_W-1:0]   chan_ff;
   logic signed [SAMPLE_W-1:0] x_ff;

   logic [ROW_W-1:0]    xrow, yrow;
   logic signed [NUM_W-1:0] num_ff, num_in;

   logic signed [COEF_W-1:0] op_a;
   logic signed [NUM_W-1:0]  op_b;
   logic signed [54:0]       pl_ff;
   logic signed [53:0]       ph_ff;
   logic                     p1_valid_ff, p1_neg_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     p2_valid_ff, p2_neg_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic signed [ACC_W-1:0]  rsum;
   logic signed [37:0]       yfull;
   logic signed [SAMPLE_W-1:0] ysat;
   logic                     sat;

   logic         rsp_valid_ff;
   lpf4_rsp_type rsp_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
         for (int i = 0; i < 4; i++) fb_ff[i] <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_GAIN: gain_ff  <= csr_wdata[GAIN_W-1:0];
            REG_FB1:  fb_ff[0] <= csr_wdata;
            REG_FB2:  fb_ff[1] <= csr_wdata;
            REG_FB3:  fb_ff[2] <= csr_wdata;
            REG_FB4:  fb_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign sts.req_clear    = (req_payload.kind == KIND_CLEAR);
   assign sts.req_in_range = (32'(req_payload.chan) < MAX_CHANNELS);
   assign sts.out_busy     = rsp_valid_ff && rsp_stall;

   // row valid bits: a row never written since the last clear reads as zero
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         row_valid_ff <= '0;
      end else if (cmd.finish) begin
         row_valid_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         rd_x_ff     <= mem_x[CH_W'(req_payload.chan)];
         rd_y_ff     <= mem_y[CH_W'(req_payload.chan)];
         rd_valid_ff <= row_valid_ff[CH_W'(req_payload.chan)];
         idx_ff      <= CH_W'(req_payload.chan);
         chan_ff     <= req_payload.chan;
         x_ff        <= req_payload.in_sample;
      end
      if (cmd.finish) begin
         mem_x[idx_ff] <= {xrow[ROW_W-SAMPLE_W-1:0], x_ff};
         mem_y[idx_ff] <= {yrow[ROW_W-SAMPLE_W-1:0], ysat};
      end
   end

   assign xrow = rd_valid_ff ? rd_x_ff : '0;
   assign yrow = rd_valid_ff ? rd_y_ff : '0;

   // binomial numerator x + 4x1 + 6x2 + 4x3 + x4
   always_comb begin
      logic signed [NUM_W-1:0] x0, x1, x2, x3, x4;
      x0 = NUM_W'(x_ff);
      x1 = NUM_W'($signed(xrow[23:0]));
      x2 = NUM_W'($signed(xrow[47:24]));
      x3 = NUM_W'($signed(xrow[71:48]));
      x4 = NUM_W'($signed(xrow[95:72]));
      num_in = x0 + ((x1 + x3) <<< 2) + (x2 <<< 2) + (x2 <<< 1) + x4;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_num) num_ff <= num_in;
   end

   always_comb begin
      case (cmd.mul_sel)
         3'd1:    op_a = fb_ff[0];
         3'd2:    op_a = fb_ff[1];
         3'd3:    op_a = fb_ff[2];
         3'd4:    op_a = fb_ff[3];
         default: op_a = $signed({4'b0, gain_ff});
      endcase
      case (cmd.mul_sel)
         3'd1:    op_b = NUM_W'($signed(yrow[23:0]));
         3'd2:    op_b = NUM_W'($signed(yrow[47:24]));
         3'd3:    op_b = NUM_W'($signed(yrow[71:48]));
         3'd4:    op_b = NUM_W'($signed(yrow[95:72]));
         default: op_b = num_ff;
      endcase
   end

   // a 27x28 and a 26x28 partial product per cycle
   always_ff @(posedge clock) begin
      pl_ff   <= $signed({1'b0, op_a[25:0]}) * op_b;
      ph_ff   <= $signed(op_a[51:26]) * op_b;
      prod_ff <= {ph_ff, 26'b0} + {{25{pl_ff[54]}}, pl_ff};
      p1_neg_ff <= (cmd.mul_sel != SEL_GAIN);
      p2_neg_ff <= p1_neg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.mul_en;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   // feedback terms are scaled by 16 and subtracted
   always_comb begin
      acc_in = acc_ff;
      if (p2_valid_ff) begin
         if (p2_neg_ff) acc_in = acc_ff - {{2{prod_ff[PROD_W-1]}}, prod_ff, 4'b0};
         else           acc_in = acc_ff + {{6{prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_num) acc_ff <= '0;
      else              acc_ff <= acc_in;
   end

   // round half up at the sample lsb, then clamp
   always_comb begin
      rsum  = acc_ff + (ACC_W'(1) <<< 47);
      yfull = rsum[ACC_W-1:48];
      sat   = 1'b0;
      ysat  = yfull[SAMPLE_W-1:0];
      if (yfull > 38'sd8388607) begin
         ysat = 24'sh7FFFFF;
         sat  = 1'b1;
      end else if (yfull < -38'sd8388608) begin
         ysat = 24'sh800000;
         sat  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.out_chan   <= chan_ff;
         rsp_ff.out_sample <= ysat;
         rsp_ff.saturated  <= sat;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: design/lpf4_ctrl.sv
// ----------------------------------------------------------------------------
// lpf4_ctrl
// sequencer: take, numerator, five product steps, pipeline drain, finish
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpf4_ctrl import lpf4_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output lpf4_cmd_type cmd,
   input  lpf4_sts_type sts
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_WAIT = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take      = sts.req_in_range && !sts.req_clear;
               cmd.clear_all = sts.req_clear;
               if (!sts.req_clear && sts.req_in_range) state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load_num = 1'b1;
            cnt_in       = '0;
            state_in     = S_MUL;
         end
         S_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cnt_ff;
            cnt_in      = cnt_ff + 3'd1;
            if (cnt_ff == SEL_LAST) begin
               cnt_in   = '0;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // products still in flight through the two pipeline stages
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd1) state_in = S_FIN;
         end
         S_FIN: begin
            if (!sts.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   `CHK_PROP(a_mul_count, clock, reset, (state_ff == S_MUL) |-> (cnt_ff <= SEL_LAST))
   `CHK_NEVER(a_finish_busy, clock, reset, cmd.finish && sts.out_busy)
   `CHK_PROP(a_take_path, clock, reset, cmd.take |=> (state_ff == S_LOAD) ##1 (state_ff == S_MUL))
   `CHK_PROP(a_finish_idle, clock, reset, cmd.finish |=> (state_ff == S_IDLE))

endmodule

// File: design/lowpass_iir_order4_multichannel.sv
// ----------------------------------------------------------------------------
// lowpass_iir_order4_multichannel
// fourth-order direct-form-I lowpass with per-channel history
// ----------------------------------------------------------------------------
//  channel  ports                            dir  beat
//  req      req_valid/req_stall/req_payload  in   kind, chan, in_sample
//  rsp      rsp_valid/rsp_stall/rsp_payload  out  out_chan, out_sample, saturated
//  csr      csr_valid/csr_ready/csr_index/   in   register write, always ready
//           csr_wdata
//
// a sample beat runs history read, numerator, five product steps on a 27x28
// and a 26x28 multiplier, pipeline drain and finish
// a clear beat or an out-of-range channel is handled without leaving the idle state
// history rows have per-channel valid bits, so reset and clear need no sweep
// a result waits in the output register; a new beat is taken meanwhile, and
// the finish step holds only if that register is still stalled
// ----------------------------------------------------------------------------
module lowpass_iir_order4_multichannel import lpf4_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lpf4_req_type         req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lpf4_rsp_type         rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata
);

   lpf4_cmd_type cmd;
   lpf4_sts_type sts;

   assign csr_ready = 1'b1;

   lpf4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   lpf4_dp #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule
